[rtl/core/rscb_pkg.sv]
// ----------------------------------------------------------------------------
// rscb_pkg
// Shared types and constants for the run-length sprite span clip blitter.
// ----------------------------------------------------------------------------
package rscb_pkg;

    // Configuration register indexes.
    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SRC_LEFT      = 3'd0;
    localparam t_cfg_idx CFG_VISIBLE_WIDTH = 3'd1;
    localparam t_cfg_idx CFG_SRC_TOP       = 3'd2;
    localparam t_cfg_idx CFG_VISIBLE_ROWS  = 3'd3;
    localparam t_cfg_idx CFG_DEST_BASE     = 3'd4;
    localparam t_cfg_idx CFG_DEST_PITCH    = 3'd5;

    // Packed widths of the stream data buses.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 80;

    // Clip window and destination geometry.
    typedef struct packed {
        logic [11:0] src_left;
        logic [12:0] visible_width;
        logic [11:0] src_top;
        logic [12:0] visible_rows;
        logic [15:0] dest_pitch;
    } t_cfg;

    // A write to the destination base starts a new sprite.
    typedef struct packed {
        logic        load;
        logic [31:0] base;
    } t_sprite_start;

    // One incoming span.
    typedef struct packed {
        logic [15:0] span_x;
        logic [15:0] span_len;
        logic [31:0] color;
        logic        line_end;
    } t_span;

    // One outgoing fill command.
    typedef struct packed {
        logic [31:0] write_addr;
        logic [12:0] pixel_count;
        logic [31:0] fill_color;
        logic        draw_done;
    } t_fill;

endpackage

[rtl/core/rscb_cfg.sv]
// ----------------------------------------------------------------------------
// rscb_cfg
// Configuration register file; flags a new sprite on a base address write.
// ----------------------------------------------------------------------------
module rscb_cfg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  rscb_pkg::t_cfg_idx     i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    output rscb_pkg::t_cfg         o_cfg,
    output rscb_pkg::t_sprite_start o_start
);
    import rscb_pkg::*;

    t_cfg r_cfg;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_left      <= '0;
            r_cfg.visible_width <= 13'd4096;
            r_cfg.src_top       <= '0;
            r_cfg.visible_rows  <= '0;
            r_cfg.dest_pitch    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_LEFT:      r_cfg.src_left      <= i_cfg_data[11:0];
                CFG_VISIBLE_WIDTH: r_cfg.visible_width <= i_cfg_data[12:0];
                CFG_SRC_TOP:       r_cfg.src_top       <= i_cfg_data[11:0];
                CFG_VISIBLE_ROWS:  r_cfg.visible_rows  <= i_cfg_data[12:0];
                CFG_DEST_PITCH:    r_cfg.dest_pitch    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

    // The base address goes straight into the row address register.
    assign o_start.load = i_cfg_valid && (i_cfg_index == CFG_DEST_BASE);
    assign o_start.base = i_cfg_data;

endmodule

[rtl/core/rscb_clip.sv]
// ----------------------------------------------------------------------------
// rscb_clip
// Line tracking state and single-pass span clipping and address generation.
// ----------------------------------------------------------------------------
module rscb_clip #(
    parameter int MAX_COORD_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rscb_pkg::t_cfg          i_cfg,
    input  rscb_pkg::t_sprite_start i_start,
    input  logic                    i_fire,
    input  rscb_pkg::t_span         i_span,
    output logic                    o_emit,
    output rscb_pkg::t_fill         o_fill
);
    import rscb_pkg::*;

    localparam logic [17:0] COORD_LIM = 18'(2 ** MAX_COORD_BITS);

    logic [15:0]        r_line;
    logic [31:0]        r_row;
    logic               r_skip;
    logic [15:0]        n_line;
    logic [31:0]        n_row;
    logic               n_skip;

    logic [12:0]        w;
    logic signed [18:0] w_s;
    logic signed [18:0] dx;
    logic signed [18:0] end_x;
    logic signed [18:0] start_x;
    logic signed [18:0] end_c;
    logic signed [18:0] cnt;
    logic               beyond;
    logic [15:0]        row_off;
    logic               visible;
    logic               last_row;

    // Visible width limited to the coordinate range.
    assign w   = ({5'b0, i_cfg.visible_width} > COORD_LIM) ? COORD_LIM[12:0]
                                                           : i_cfg.visible_width;
    assign w_s = $signed({6'b0, w});

    // Row window test on the current source line.
    assign row_off  = r_line - {4'b0, i_cfg.src_top};
    assign visible  = (r_line >= {4'b0, i_cfg.src_top}) &&
                      (row_off < {3'b0, i_cfg.visible_rows});
    assign last_row = ({1'b0, row_off} + 17'd1) == {4'b0, i_cfg.visible_rows};

    // Horizontal clip: both ends are worked out side by side.
    assign dx      = $signed({3'b0, i_span.span_x}) - $signed({7'b0, i_cfg.src_left});
    assign end_x   = dx + $signed({3'b0, i_span.span_len});
    assign start_x = dx[18] ? '0 : dx;
    assign end_c   = (end_x > w_s) ? w_s : end_x;
    assign cnt     = end_c - start_x;
    assign beyond  = dx > w_s;

    assign o_emit = visible && !r_skip && !beyond && !cnt[18] && (cnt != '0);

    assign o_fill.write_addr  = r_row + {17'b0, start_x[12:0], 2'b00};
    assign o_fill.pixel_count = cnt[12:0];
    assign o_fill.fill_color  = i_span.color;
    assign o_fill.draw_done   = i_span.line_end && visible && last_row;

    // Next state for an item leaving the input register.
    always_comb begin
        n_line = r_line;
        n_row  = r_row;
        n_skip = r_skip;
        if (visible && !r_skip && beyond) begin
            n_skip = 1'b1;
        end
        if (i_span.line_end) begin
            if (visible) begin
                n_row = r_row + {16'b0, i_cfg.dest_pitch};
            end
            if (r_line != 16'hFFFF) begin
                n_line = r_line + 16'd1;
            end
            n_skip = 1'b0;
        end
    end

    // Line state; a base address write starts a new sprite.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
            r_row  <= '0;
            r_skip <= 1'b0;
        end else if (i_start.load) begin
            r_line <= '0;
            r_row  <= i_start.base;
            r_skip <= 1'b0;
        end else if (i_fire) begin
            r_line <= n_line;
            r_row  <= n_row;
            r_skip <= n_skip;
        end
    end

endmodule

[rtl/core/rle_span_clip_blitter.sv]
// ----------------------------------------------------------------------------
// rle_span_clip_blitter
// Turns run-length coded sprite spans into clipped fill commands.
// ----------------------------------------------------------------------------
// One span is taken every clock cycle unless input is stalled. A span passes
// an input register and the clip logic into the result register as a fill
// command, if it gives one. Spans on hidden lines, spans clipped away and spans
// after one that starts right of the window give no command. Input is
// stalled only while both the input register and a waiting result are full.
// Configuration writes are always accepted; write them only while idle.
// ----------------------------------------------------------------------------
module rle_span_clip_blitter #(
    parameter int MAX_COORD_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Span stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: span_x[15:0], span_len[31:16], color[63:32]
    input  logic [rscb_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // tlast: line_end
    input  logic                                 s_axis_tlast,
    // Fill command stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: write_addr[31:0], pixel_count[44:32], fill_color[76:45], zeros
    output logic [rscb_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // tlast: draw_done
    output logic                                 m_axis_tlast,
    // Configuration writes.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  rscb_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);
    import rscb_pkg::*;

    t_cfg          cfg;
    t_sprite_start start;
    t_span         in_span;
    t_fill         fill;
    logic          emit;
    logic          advance;

    logic          r_in_valid;
    t_span         r_in;
    logic          r_out_valid;
    t_fill         r_out;

    assign o_cfg_ready = 1'b1;

    rscb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_start     (start)
    );

    // Unpack the incoming item.
    assign in_span.span_x   = s_axis_tdata[15:0];
    assign in_span.span_len = s_axis_tdata[31:16];
    assign in_span.color    = s_axis_tdata[63:32];
    assign in_span.line_end = s_axis_tlast;

    // The held item moves on when the result register is free or draining.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    rscb_clip #(
        .MAX_COORD_BITS (MAX_COORD_BITS)
    ) u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_start (start),
        .i_fire  (advance),
        .i_span  (r_in),
        .o_emit  (emit),
        .o_fill  (fill)
    );

    // Input and result valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= in_span;
        end
        if (advance && emit) begin
            r_out <= fill;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b0, r_out.fill_color, r_out.pixel_count, r_out.write_addr};
    assign m_axis_tlast  = r_out.draw_done;

endmodule

[rtl/core/rscb_checker.sv]
// ----------------------------------------------------------------------------
// rscb_checker
// Port-level checks for the span clip blitter, bound to the top level.
// ----------------------------------------------------------------------------
module rscb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled command holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("fill command changed while stalled");

    // A fill command never has an empty pixel count.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[44:32] != 13'd0))
        else $error("fill command with zero pixels");

    // Input stalls only behind a full, blocked result register.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a blocked result");

    // No command in the first cycle after reset is released.
    a_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind rle_span_clip_blitter rscb_checker u_rscb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the run-length sprite span clip blitter.
// ----------------------------------------------------------------------------
// Spans are queued by the stimulus process and offered by a clocked driver
// that also applies register writes. Every accepted span goes through a
// behavioural copy of the clip window and the line counter. The fill commands
// that copy predicts are held in order, and a clocked monitor compares each
// command from the block against them, field by field. Both stream sides idle
// at random. The stimulus covers directed corner spans, a long receiver stall,
// and many random windows and sprites.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rscb_pkg::*;

    localparam int COORD_BITS     = 12;
    localparam int COORD_LIM      = 1 << COORD_BITS;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STALL_LIMIT    = 4000;
    localparam int IDLE_PERCENT   = 14;
    localparam int N_PHASES       = 34;

    // Register indexes that the block does not decode.
    localparam t_cfg_idx CFG_UNUSED_6 = 3'd6;
    localparam t_cfg_idx CFG_UNUSED_7 = 3'd7;

    typedef struct {
        t_cfg_idx    idx;
        logic [31:0] data;
    } t_reg_write;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    t_cfg_idx             i_cfg_index   = CFG_SRC_LEFT;
    logic [31:0]          i_cfg_data    = '0;

    rle_span_clip_blitter #(
        .MAX_COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Pending stimulus and predicted fill commands.
    t_span      span_q[$];
    t_reg_write reg_q[$];
    t_fill      fill_q[$];

    // Shared controls and counters.
    bit vary_off    = 1'b0;
    int rx_hold_req = 0;
    int n_spans     = 0;
    int n_fills     = 0;
    int n_writes    = 0;
    int n_err       = 0;
    int n_windows   = 0;

    // Behavioural copy of the window registers and the sprite state.
    logic [11:0] w_left;
    logic [12:0] w_width;
    logic [11:0] w_top;
    logic [12:0] w_rows;
    logic [31:0] w_base;
    logic [15:0] w_pitch;
    logic [15:0] cur_line;
    logic [31:0] cur_row;
    logic        line_skip;

    function automatic void reset_window();
        w_left    = '0;
        w_width   = 13'(COORD_LIM);
        w_top     = '0;
        w_rows    = '0;
        w_base    = '0;
        w_pitch   = '0;
        cur_line  = '0;
        cur_row   = '0;
        line_skip = 1'b0;
    endfunction

    // A write to the destination base also starts a new sprite.
    function automatic void apply_register(t_cfg_idx idx, logic [31:0] d);
        case (idx)
            CFG_SRC_LEFT:      w_left  = d[11:0];
            CFG_VISIBLE_WIDTH: w_width = d[12:0];
            CFG_SRC_TOP:       w_top   = d[11:0];
            CFG_VISIBLE_ROWS:  w_rows  = d[12:0];
            CFG_DEST_BASE: begin
                w_base    = d;
                cur_row   = d;
                cur_line  = '0;
                line_skip = 1'b0;
            end
            CFG_DEST_PITCH:    w_pitch = d[15:0];
            default: ;
        endcase
    endfunction

    // Clips one span against the window and queues the fill it should give.
    function automatic void predict_fill(t_span sp);
        int    w;
        int    rel;
        int    dx;
        int    cnt;
        bit    vis;
        bit    done;
        t_fill f;
        w    = (int'(w_width) > COORD_LIM) ? COORD_LIM : int'(w_width);
        rel  = int'(cur_line) - int'(w_top);
        vis  = (rel >= 0) && (rel < int'(w_rows));
        done = sp.line_end && vis && (rel == int'(w_rows) - 1);
        if (vis && !line_skip) begin
            dx = int'(sp.span_x) - int'(w_left);
            if (dx > w) begin
                line_skip = 1'b1;
            end else begin
                cnt = int'(sp.span_len);
                if (dx < 0) begin
                    cnt += dx;
                    dx = 0;
                end
                if (dx + cnt > w) cnt = w - dx;
                if (cnt > 0) begin
                    f.write_addr  = cur_row + 32'(dx) * 32'd4;
                    f.pixel_count = cnt[12:0];
                    f.fill_color  = sp.color;
                    f.draw_done   = done;
                    fill_q.push_back(f);
                end
            end
        end
        // The row address only moves on at the end of a visible line.
        if (sp.line_end) begin
            if (vis) cur_row = cur_row + 32'(w_pitch);
            if (cur_line != 16'hFFFF) cur_line = cur_line + 16'd1;
            line_skip = 1'b0;
        end
    endfunction

    // Driver: register writes and spans, with the prediction at acceptance.
    always @(posedge i_clk) begin : span_driver
        t_span      sp;
        t_reg_write rw;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid   <= 1'b0;
            reset_window();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
                n_writes++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sp.span_x   = s_axis_tdata[15:0];
                sp.span_len = s_axis_tdata[31:16];
                sp.color    = s_axis_tdata[63:32];
                sp.line_end = s_axis_tlast;
                predict_fill(sp);
                n_spans++;
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (reg_q.size() > 0) begin
                    rw = reg_q.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= rw.idx;
                    i_cfg_data  <= rw.data;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (span_q.size() > 0 &&
                    (vary_off || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    sp = span_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {sp.color, sp.span_len, sp.span_x};
                    s_axis_tlast  <= sp.line_end;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness, with a long hold-off whenever one is requested.
    always @(posedge i_clk) begin : fill_receiver
        int hold_left;
        int hold_seen;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end else if (hold_seen != rx_hold_req) begin
            hold_seen = rx_hold_req;
            hold_left = RX_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= vary_off || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Monitor: each fill command against the oldest prediction.
    always @(posedge i_clk) begin : fill_monitor
        t_fill got;
        t_fill want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.write_addr  = m_axis_tdata[31:0];
            got.pixel_count = m_axis_tdata[44:32];
            got.fill_color  = m_axis_tdata[76:45];
            got.draw_done   = m_axis_tlast;
            n_fills++;
            if (fill_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected fill: addr=%h count=%0d colour=%h done=%b",
                             got.write_addr, got.pixel_count, got.fill_color,
                             got.draw_done);
            end else begin
                want = fill_q.pop_front();
                if (got.write_addr !== want.write_addr ||
                    got.pixel_count !== want.pixel_count ||
                    got.fill_color !== want.fill_color ||
                    got.draw_done !== want.draw_done) begin
                    n_err++;
                    if (n_err <= 10)
                        $display({"fill %0d mismatch: expected addr=%h count=%0d ",
                                  "colour=%h done=%b, got addr=%h count=%0d ",
                                  "colour=%h done=%b"},
                                 n_fills, want.write_addr, want.pixel_count,
                                 want.fill_color, want.draw_done, got.write_addr,
                                 got.pixel_count, got.fill_color, got.draw_done);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin : stall_watchdog
        int quiet;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("no handshake for %0d cycles, %0d fills outstanding",
                         quiet, fill_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic push_span(int x, int len, logic [31:0] colour, bit last);
        t_span sp;
        sp.span_x   = 16'(x);
        sp.span_len = 16'(len);
        sp.color    = colour;
        sp.line_end = last;
        span_q.push_back(sp);
    endtask

    // Unused upper bits of the write data carry junk.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] value, int bits);
        t_reg_write rw;
        rw.idx  = idx;
        rw.data = ($urandom << bits) | value;
        reg_q.push_back(rw);
    endtask

    // Waits until every span is taken and every fill has come back.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (span_q.size() > 0 || s_axis_tvalid || fill_q.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_window(int left, int width, int top, int rows,
                              logic [31:0] base, int pitch, bit restart);
        write_reg(CFG_SRC_LEFT, 32'(left), 12);
        write_reg(CFG_VISIBLE_WIDTH, 32'(width), 13);
        write_reg(CFG_SRC_TOP, 32'(top), 12);
        write_reg(CFG_VISIBLE_ROWS, 32'(rows), 13);
        write_reg(CFG_DEST_PITCH, 32'(pitch), 16);
        if (restart) write_reg(CFG_DEST_BASE, base, 32);
        do @(negedge i_clk);
        while (reg_q.size() > 0 || i_cfg_valid);
        n_windows++;
    endtask

    // Stimulus.
    initial begin : stimulus
        int left;
        int width;
        int top;
        int rows;
        int pitch;
        int w_eff;
        int items;
        int nsp;
        int cur;
        int x;
        int len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Window of columns 0..199 at source x 100, lines 1..3 drawn.
        set_window(100, 200, 1, 3, 32'h0000_1000, 16'h0400, 1'b1);
        push_span(150, 10, 32'hFFFF_FFFF, 1'b1);   // hidden line
        push_span(0, 50, 32'h0, 1'b0);             // wholly left of the window
        push_span(90, 20, $urandom, 1'b0);         // clipped on the left
        push_span(100, 0, $urandom, 1'b0);         // zero length
        push_span(150, 1000, $urandom, 1'b0);      // clipped on the right
        push_span(300, 5, $urandom, 1'b0);         // starts exactly at the width
        push_span(301, 5, $urandom, 1'b0);         // starts right of the window
        push_span(120, 5, $urandom, 1'b1);         // rest of that line dropped
        push_span(0, 0, 32'h0, 1'b1);              // empty line marker
        push_span(100, 200, $urandom, 1'b0);       // full width
        push_span(299, 65535, $urandom, 1'b1);     // ends the last visible line
        push_span(100, 5, $urandom, 1'b1);         // below the window
        wait_idle();

        // Extreme window with wrapping addresses.
        set_window(4095, 4096, 0, 4096, 32'hFFFF_FFF0, 16'hFFFF, 1'b1);
        push_span(65535, 65535, 32'hFFFF_FFFF, 1'b0);
        push_span(4095, 65535, 32'h0, 1'b1);
        push_span(4095, 65535, 32'hFFFF_FFFF, 1'b1);
        push_span(0, 65535, 32'h0, 1'b1);
        wait_idle();

        // The last visible line loses its done mark when its span is dropped.
        set_window(0, 1, 0, 1, $urandom, $urandom_range(0, 65535), 1'b1);
        push_span(5, 3, $urandom, 1'b1);
        wait_idle();

        // A width of zero draws nothing.
        set_window(0, 0, 0, 2, $urandom, $urandom_range(0, 65535), 1'b1);
        push_span(0, 10, $urandom, 1'b0);
        push_span(0, 1, $urandom, 1'b1);
        wait_idle();

        // Over-range width, with writes to undecoded indexes ahead of it.
        write_reg(CFG_UNUSED_6, $urandom, 0);
        write_reg(CFG_UNUSED_7, $urandom, 0);
        set_window(10, 8191, 0, 2, 32'h0000_8000, 16, 1'b1);
        push_span(10, 5000, $urandom, 1'b1);
        push_span(20, 3, $urandom, 1'b1);
        wait_idle();

        // Receiver holds off while visible spans keep arriving.
        set_window(0, 4096, 0, 4096, $urandom, $urandom_range(0, 65535), 1'b1);
        rx_hold_req++;
        for (int k = 0; k < 80; k++)
            push_span($urandom_range(0, 3000), $urandom_range(1, 200), $urandom,
                      $urandom_range(0, 99) < 30);
        wait_idle();

        // Random windows, each followed by a mostly well-formed sprite.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0, 1:    left = 0;
                2:       left = 4095;
                default: left = $urandom_range(0, 300);
            endcase
            case ($urandom_range(0, 19))
                0, 1:    width = 4096;
                2:       width = 1;
                3:       width = 8191;
                default: width = $urandom_range(1, 400);
            endcase
            top  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                              : $urandom_range(0, 4);
            case ($urandom_range(0, 9))
                0:       rows = 0;
                1:       rows = 4096;
                default: rows = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       pitch = 0;
                1:       pitch = 65535;
                default: pitch = $urandom_range(0, 65535);
            endcase
            w_eff    = (width > COORD_LIM) ? COORD_LIM : width;
            vary_off = (ph >= 12 && ph < 18);
            set_window(left, width, top, rows, $urandom, pitch,
                       $urandom_range(0, 4) != 0);
            items = 0;
            while (items < 32) begin
                if ($urandom_range(0, 99) < 6) begin
                    push_span($urandom_range(0, 65535), 0, $urandom, 1'b1);
                    items++;
                    continue;
                end
                nsp = $urandom_range(1, 4);
                cur = left - $urandom_range(0, 40);
                if (cur < 0) cur = 0;
                for (int k = 0; k < nsp; k++) begin
                    if ($urandom_range(0, 99) < 10) begin
                        // Noise: any field value at all.
                        push_span($urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom, $urandom_range(0, 1));
                    end else begin
                        x   = cur + $urandom_range(0, w_eff / 3 + 4);
                        len = ($urandom_range(0, 19) == 0) ? 0
                                : $urandom_range(1, w_eff / 3 + 10);
                        if (x > 65535) x = 65535;
                        cur = x + len;
                        push_span(x, len, $urandom, k == nsp - 1);
                    end
                    items++;
                end
            end
            wait_idle();
        end
        vary_off = 1'b0;

        repeat (20) @(negedge i_clk);
        $display("Ran %0d spans through %0d windows with %0d register writes;",
                 n_spans, n_windows, n_writes);
        $display("checked %0d fill commands, including a long receiver stall",
                 n_fills);
        if (n_err == 0 && fill_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d fills never arrived", n_err, fill_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[rle_span_clip_blitter.f]
rtl/core/rscb_pkg.sv
rtl/core/rscb_cfg.sv
rtl/core/rscb_clip.sv
rtl/core/rle_span_clip_blitter.sv
rtl/core/rscb_checker.sv
tb/sv/tb.sv
